// File: sv/rbs_pkg.sv
// Shared constants for the ray/box slab test.
package rbs_pkg;
    localparam int NUM_AXES = 3;
    localparam int AXIS_X   = 0;
    localparam int AXIS_Y   = 1;
    localparam int AXIS_Z   = 2;

    typedef struct packed {
        logic adv;
        logic rst_n;
    } t_stage_ctl;
endpackage

// File: sv/rbs_if.sv
// Ray/box input channel and hit result channel.
interface rbs_ray_if #(parameter int W = 32);
    logic valid;
    logic ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    logic signed [W-1:0] box_lo_x;
    logic signed [W-1:0] box_lo_y;
    logic signed [W-1:0] box_lo_z;
    logic signed [W-1:0] box_hi_x;
    logic signed [W-1:0] box_hi_y;
    logic signed [W-1:0] box_hi_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  output ready);
endinterface

interface rbs_hit_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// File: sv/rbs_div.sv
// Pipelined saturating fixed-point divider, one quotient bit per stage.
module rbs_div
    import rbs_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  t_stage_ctl          i_ctl,
    input  logic signed [W:0]   i_num,
    input  logic signed [W-1:0] i_den,
    output logic signed [W-1:0] o_quo
);
    localparam int DW = 2 * W + F;

    logic [DW-1:0]  r_rem [0:W-1];
    logic [W-1:0]   r_den [0:W-1];
    logic [W-2:0]   r_q   [0:W-1];
    logic           r_neg [0:W-1];
    logic           r_sat [0:W-1];
    logic signed [W-1:0] r_quo;

    logic [W:0]    n_un;
    logic [W-1:0]  n_ud;
    logic [DW-1:0] n_num_w;
    logic [DW-1:0] n_lim;

    always_comb begin
        n_un    = i_num[W] ? (W+1)'(-i_num) : i_num;
        n_ud    = i_den[W-1] ? W'(-i_den) : i_den;
        n_num_w = DW'({n_un, {F{1'b0}}});
        n_lim   = DW'(n_ud) << (W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_rem[0] <= n_num_w;
            r_den[0] <= n_ud;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[W] ^ i_den[W-1];
            r_sat[0] <= n_num_w >= n_lim;
        end
    end

    for (genvar s = 1; s < W; s++) begin : g_stage
        localparam int K = W - 1 - s;
        logic [DW-1:0] n_sub;
        logic          n_ge;
        assign n_sub = DW'(r_den[s-1]) << K;
        assign n_ge  = r_rem[s-1] >= n_sub;
        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rem[s] <= n_ge ? r_rem[s-1] - n_sub : r_rem[s-1];
                r_q[s]   <= n_ge ? (r_q[s-1] | ((W-1)'(1) << K)) : r_q[s-1];
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
                r_sat[s] <= r_sat[s-1];
            end
        end
    end

    logic [W-1:0] n_qf;
    assign n_qf = {1'b0, r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            if (r_sat[W-1]) begin
                r_quo <= r_neg[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                r_quo <= r_neg[W-1] ? W'(-n_qf) : n_qf;
            end
        end
    end

    assign o_quo = r_quo;
endmodule

// File: sv/rbs_lane.sv
// One axis lane: slab bounds in t for one ray component.
module rbs_lane
    import rbs_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  t_stage_ctl          i_ctl,
    input  logic signed [W-1:0] i_org,
    input  logic signed [W-1:0] i_dir,
    input  logic signed [W-1:0] i_lo,
    input  logic signed [W-1:0] i_hi,
    output logic signed [W-1:0] o_tmin,
    output logic signed [W-1:0] o_tmax,
    output logic                o_ok
);
    localparam int DLAT = W + 1;

    logic signed [W:0]   r_nlo;
    logic signed [W:0]   r_nhi;
    logic signed [W-1:0] r_dir;
    logic                r_dz  [0:DLAT];
    logic                r_in  [0:DLAT];
    logic signed [W-1:0] r_tmin;
    logic signed [W-1:0] r_tmax;
    logic                r_ok;
    logic signed [W-1:0] w_qa;
    logic signed [W-1:0] w_qb;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_nlo <= {i_lo[W-1], i_lo} - {i_org[W-1], i_org};
            r_nhi <= {i_hi[W-1], i_hi} - {i_org[W-1], i_org};
            r_dir <= i_dir;
            r_dz[0] <= i_dir == '0;
            r_in[0] <= (i_lo <= i_org) && (i_org <= i_hi);
            for (int s = 1; s <= DLAT; s++) begin
                r_dz[s] <= r_dz[s-1];
                r_in[s] <= r_in[s-1];
            end
        end
    end

    rbs_div #(.W(W), .F(F)) u_div_lo (
        .i_clk(i_clk), .i_ctl(i_ctl), .i_num(r_nlo), .i_den(r_dir), .o_quo(w_qa));
    rbs_div #(.W(W), .F(F)) u_div_hi (
        .i_clk(i_clk), .i_ctl(i_ctl), .i_num(r_nhi), .i_den(r_dir), .o_quo(w_qb));

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            if (r_dz[DLAT]) begin
                r_ok   <= r_in[DLAT];
                r_tmin <= {1'b1, {(W-1){1'b0}}};
                r_tmax <= {1'b0, {(W-1){1'b1}}};
            end else begin
                r_ok   <= 1'b1;
                r_tmin <= (w_qa > w_qb) ? w_qb : w_qa;
                r_tmax <= (w_qa > w_qb) ? w_qa : w_qb;
            end
        end
    end

    assign o_tmin = r_tmin;
    assign o_tmax = r_tmax;
    assign o_ok   = r_ok;
endmodule

// File: sv/rbs_merge.sv
// Merge of the three slab intervals into the hit flag.
module rbs_merge
    import rbs_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  t_stage_ctl          i_ctl,
    input  logic signed [W-1:0] i_tmin [NUM_AXES],
    input  logic signed [W-1:0] i_tmax [NUM_AXES],
    input  logic                i_ok   [NUM_AXES],
    output logic                o_hit
);
    logic signed [W-1:0] r_amin, r_amax, r_zmin, r_zmax;
    logic                r_aok, r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_aok  <= i_ok[AXIS_X] && i_ok[AXIS_Y] && i_ok[AXIS_Z]
                      && !(i_tmin[AXIS_X] > i_tmax[AXIS_Y])
                      && !(i_tmin[AXIS_Y] > i_tmax[AXIS_X]);
            r_amin <= (i_tmin[AXIS_Y] > i_tmin[AXIS_X]) ? i_tmin[AXIS_Y] : i_tmin[AXIS_X];
            r_amax <= (i_tmax[AXIS_Y] < i_tmax[AXIS_X]) ? i_tmax[AXIS_Y] : i_tmax[AXIS_X];
            r_zmin <= i_tmin[AXIS_Z];
            r_zmax <= i_tmax[AXIS_Z];
            r_hit  <= r_aok && !(r_amin > r_zmax) && !(r_zmin > r_amax);
        end
    end

    assign o_hit = r_hit;
endmodule

// File: sv/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test, top level.
// Usage:
//   i_ray carries one ray (origin, direction) and one box (lo, hi corner)
//   per transfer, all signed fixed point with FRAC_BITS fraction bits.
//   o_hit returns one flag per transfer: 1 when the ray line crosses all
//   three slabs, negative t included.
// Pipeline: lane input registers, the bit-per-stage dividers (two per lane
//   in each of the three axis lanes), the lane min/max registers and the
//   merge registers lie between an input transfer and o_hit.valid.
// Throughput: one transfer per cycle while no result in o_hit is held back.
// Stall: the whole pipeline holds while a result sits in o_hit unaccepted;
//   i_ray.ready then drops. A result leaving frees the pipe in that cycle.
// Reset: synchronous, active low; clears all valid flags, no result pending.
module ray_box_slab_test
    import rbs_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbs_ray_if.sink     i_ray,
    rbs_hit_if.source   o_hit
);
    localparam int LAT = COORD_WIDTH + 5;

    logic [LAT-1:0]             r_vld;
    t_stage_ctl                 w_ctl;
    logic signed [COORD_WIDTH-1:0] w_org  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_dir  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_lo   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_hi   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_tmin [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_tmax [NUM_AXES];
    logic                          w_ok   [NUM_AXES];

    assign w_ctl.adv   = !r_vld[LAT-1] || o_hit.ready;
    assign w_ctl.rst_n = i_rst_n;
    assign i_ray.ready = w_ctl.adv;

    assign w_org[AXIS_X] = i_ray.origin_x;
    assign w_org[AXIS_Y] = i_ray.origin_y;
    assign w_org[AXIS_Z] = i_ray.origin_z;
    assign w_dir[AXIS_X] = i_ray.dir_x;
    assign w_dir[AXIS_Y] = i_ray.dir_y;
    assign w_dir[AXIS_Z] = i_ray.dir_z;
    assign w_lo[AXIS_X]  = i_ray.box_lo_x;
    assign w_lo[AXIS_Y]  = i_ray.box_lo_y;
    assign w_lo[AXIS_Z]  = i_ray.box_lo_z;
    assign w_hi[AXIS_X]  = i_ray.box_hi_x;
    assign w_hi[AXIS_Y]  = i_ray.box_hi_y;
    assign w_hi[AXIS_Z]  = i_ray.box_hi_z;

    always_ff @(posedge i_clk) begin
        if (!w_ctl.rst_n) begin
            r_vld <= '0;
        end else if (w_ctl.adv) begin
            r_vld <= {r_vld[LAT-2:0], i_ray.valid};
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rbs_lane #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_org  (w_org[a]),
            .i_dir  (w_dir[a]),
            .i_lo   (w_lo[a]),
            .i_hi   (w_hi[a]),
            .o_tmin (w_tmin[a]),
            .o_tmax (w_tmax[a]),
            .o_ok   (w_ok[a])
        );
    end

    rbs_merge #(.W(COORD_WIDTH)) u_merge (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_tmin (w_tmin),
        .i_tmax (w_tmax),
        .i_ok   (w_ok),
        .o_hit  (o_hit.hit)
    );

    assign o_hit.valid = r_vld[LAT-1];

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ray.ready |-> (o_hit.valid && !o_hit.ready))
        else $error("input stalled without a pending result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hit.valid)
        else $error("result valid right after reset");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit.valid && $past(i_rst_n)) |->
            ($past(r_vld[LAT-2]) || $past(o_hit.valid && !o_hit.ready)))
        else $error("result valid without a source stage");
endmodule

// File: verif/rbs_checker.sv
// Checker for the ray/box slab test: predicts hit flags and compares transfers.
`timescale 1ns / 1ps
module rbs_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rbs_ray_if       i_ray,
    rbs_hit_if       o_hit,
    output int       o_errors,
    output int       o_pending,
    output logic     o_activity
);
    localparam longint CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    bit hit_queue[$];

    function automatic longint fx_quot(longint num, longint den);
        bit      neg;
        longint  un, ud, q, r;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        r = un % ud;
        if (q >= (64'sd1 <<< (COORD_WIDTH - 1 - FRAC_BITS)))
            return neg ? CMIN : CMAX;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 1;
            end
        end
        return neg ? -q : q;
    endfunction

    function automatic bit slab_span(longint o, longint d, longint lo, longint hi,
                                     output longint tmin, output longint tmax);
        longint a, b;
        tmin = CMIN;
        tmax = CMAX;
        if (d == 0)
            return (lo <= o && o <= hi);
        a = fx_quot(lo - o, d);
        b = fx_quot(hi - o, d);
        tmin = a < b ? a : b;
        tmax = a < b ? b : a;
        return 1'b1;
    endfunction

    function automatic bit predict_hit();
        longint tn, tx, yn, yx, zn, zx;
        if (!slab_span(i_ray.origin_x, i_ray.dir_x, i_ray.box_lo_x, i_ray.box_hi_x, tn, tx))
            return 1'b0;
        if (!slab_span(i_ray.origin_y, i_ray.dir_y, i_ray.box_lo_y, i_ray.box_hi_y, yn, yx))
            return 1'b0;
        if (tn > yx || yn > tx)
            return 1'b0;
        if (yn > tn) tn = yn;
        if (yx < tx) tx = yx;
        if (!slab_span(i_ray.origin_z, i_ray.dir_z, i_ray.box_lo_z, i_ray.box_hi_z, zn, zx))
            return 1'b0;
        return !(tn > zx || zn > tx);
    endfunction

    assign o_pending  = hit_queue.size();
    assign o_activity = (i_ray.valid && i_ray.ready) || (o_hit.valid && o_hit.ready);

    always_ff @(posedge i_clk) begin
        bit exp_hit;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_ray.valid && i_ray.ready)
                hit_queue.insert(hit_queue.size(), predict_hit());
            if (o_hit.valid && o_hit.ready) begin
                if (hit_queue.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected hit transfer: hit=%0b", o_hit.hit);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_hit = hit_queue.pop_front();
                    if (exp_hit !== o_hit.hit) begin
                        if (o_errors < 10)
                            $display("hit mismatch: expected %0b got %0b", exp_hit, o_hit.hit);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: verif/tb_ray_box_slab_test.sv
// Testbench top for the ray/box slab test: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_ray_box_slab_test;
    localparam int W         = 32;
    localparam int N_RANDOM  = 1700;
    localparam int WD_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    logic activity;
    int   idle_cycles;
    int   stall_len;

    rbs_ray_if #(.W(W)) ray_ch ();
    rbs_hit_if hit_ch ();

    ray_box_slab_test uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ray(ray_ch.sink), .o_hit(hit_ch.source)
    );

    rbs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ray(ray_ch), .o_hit(hit_ch),
        .o_errors(errors), .o_pending(pending), .o_activity(activity)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls in runs; some long stretches always ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_ch.ready <= 1'b0;
            stall_len    <= 0;
        end else if (stall_len > 0) begin
            stall_len    <= stall_len - 1;
            hit_ch.ready <= 1'b0;
        end else begin
            hit_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                stall_len <= $urandom_range(1, 12);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || activity)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [W-1:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return {{(W-20){1'b0}}, 20'($urandom())} - (1 << 19);
            2: return $signed(($urandom_range(0, 64) - 32)) <<< 16;
            default: return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
        endcase
    endfunction

    task automatic send_ray(input logic [W-1:0] f[12]);
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= f[0];  ray_ch.origin_y <= f[1];  ray_ch.origin_z <= f[2];
        ray_ch.dir_x    <= f[3];  ray_ch.dir_y    <= f[4];  ray_ch.dir_z    <= f[5];
        ray_ch.box_lo_x <= f[6];  ray_ch.box_lo_y <= f[7];  ray_ch.box_lo_z <= f[8];
        ray_ch.box_hi_x <= f[9];  ray_ch.box_hi_y <= f[10]; ray_ch.box_hi_z <= f[11];
        do @(posedge i_clk); while (!ray_ch.ready);
    endtask

    task automatic idle_gap(int n);
        ray_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_ray(output logic [W-1:0] f[12]);
        int m;
        m = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            logic [W-1:0] p, q;
            f[a]     = rnd_coord(m < 3 ? 0 : (m < 8 ? 1 : (m < 9 ? 2 : 3)));
            f[a + 3] = ($urandom_range(0, 7) == 0) ? '0 : rnd_coord(m < 3 ? 0 : $urandom_range(0, 3));
            p = rnd_coord(m < 3 ? 0 : (m < 9 ? 1 : 2));
            q = rnd_coord(m < 3 ? 0 : (m < 9 ? 1 : 2));
            // mostly well-ordered boxes, some inverted
            if ($urandom_range(0, 9) != 0 && $signed(p) > $signed(q)) begin
                f[a + 6] = q; f[a + 9] = p;
            end else begin
                f[a + 6] = p; f[a + 9] = q;
            end
            if ($urandom_range(0, 5) == 0) f[a] = $urandom_range(0, 1) ? f[a + 6] : f[a + 9];
        end
    endtask

    initial begin
        logic [W-1:0] f[12];
        logic [W-1:0] maxv, minv, one;
        int burst;
        maxv = {1'b0, {(W-1){1'b1}}};
        minv = {1'b1, {(W-1){1'b0}}};
        one  = 1 << 16;
        i_rst_n = 1'b0;
        ray_ch.valid <= 1'b0;
        foreach (f[i]) f[i] = '0;
        send_ray_fields_init: begin
            ray_ch.origin_x <= '0; ray_ch.origin_y <= '0; ray_ch.origin_z <= '0;
            ray_ch.dir_x <= '0; ray_ch.dir_y <= '0; ray_ch.dir_z <= '0;
            ray_ch.box_lo_x <= '0; ray_ch.box_lo_y <= '0; ray_ch.box_lo_z <= '0;
            ray_ch.box_hi_x <= '0; ray_ch.box_hi_y <= '0; ray_ch.box_hi_z <= '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit box, axis rays, zero direction, extremes, touching, behind
        for (int k = 0; k < 20; k++) begin
            for (int a = 0; a < 3; a++) begin
                f[a] = -2 * one; f[a + 3] = one; f[a + 6] = -one; f[a + 9] = one;
            end
            case (k)
                1: begin f[3] = -one; end
                2: begin f[4] = '0; f[1] = '0; end
                3: begin f[4] = '0; f[1] = 5 * one; end
                4: begin f[5] = '0; f[2] = one; end
                5: begin f[5] = '0; f[2] = one + 1; end
                6: foreach (f[i]) f[i] = maxv;
                7: foreach (f[i]) f[i] = minv;
                8: begin f[0] = minv; f[3] = 1; f[9] = maxv; end
                9: begin f[3] = minv; f[0] = maxv; end
                10: begin f[6] = one; f[9] = -one; end
                11: begin f[3] = '0; f[0] = '0; f[6] = one; f[9] = -one; end
                12: begin f[0] = 5 * one; f[1] = 5 * one; f[2] = 5 * one; end
                13: begin f[3] = one; f[4] = 2 * one; f[1] = -2 * one; f[7] = -one; end
                14: begin f[3] = '0; f[4] = '0; f[5] = '0; f[0] = 0; f[1] = 0; f[2] = 0; end
                15: begin f[4] = one; f[7] = 2 * one; f[10] = 3 * one; f[6] = -3*one; f[9] = -one; end
                16: begin f[3] = 1; f[4] = maxv; f[5] = minv; end
                17: foreach (f[i]) f[i] = '1;
                18: begin f[0] = '0; f[3] = maxv; f[6] = minv; f[9] = maxv; end
                default: ;
            endcase
            send_ray(f);
        end
        idle_gap(1);

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                random_ray(f);
                send_ray(f);
            end
            if (n > N_RANDOM / 2 && n - burst <= N_RANDOM / 2) begin
                ray_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end else if ($urandom_range(0, 3) != 0) begin
                idle_gap($urandom_range(1, 8));
            end
        end
        ray_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (W + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
